[hw/rtl/ssds_pkg.sv]
// Package for the shortest-seek disk scheduler: sizes, item structs, states.
// No dependencies; used by every module in hw/rtl.
package ssds_pkg;

    localparam int QUEUE_DEPTH    = 16;
    localparam int MAX_REQUESTERS = 32;
    localparam int TRACK_BITS     = 10;
    localparam int IDX_W          = $clog2(QUEUE_DEPTH);
    localparam int CNT_W          = $clog2(QUEUE_DEPTH + 1);
    localparam int WHO_W          = 5;
    localparam int LIMIT_W        = 5;
    localparam int ACTIVE_W       = 6;

    localparam logic ACT_SUBMIT = 1'b0;
    localparam logic ACT_FINISH = 1'b1;
    localparam logic KIND_SERVED   = 1'b0;
    localparam logic KIND_REJECTED = 1'b1;
    localparam logic CFG_QUEUE_LIMIT = 1'b0;
    localparam logic CFG_ACTIVE      = 1'b1;

    typedef struct packed {
        logic                  action;
        logic [WHO_W-1:0]      requester;
        logic [TRACK_BITS-1:0] track;
    } t_in;

    typedef struct packed {
        logic                  kind;
        logic [WHO_W-1:0]      served_requester;
        logic [TRACK_BITS-1:0] served_track;
        logic                  last;
    } t_out;

    typedef struct packed {
        logic [WHO_W-1:0]      owner;
        logic [TRACK_BITS-1:0] track;
    } t_entry;

    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctrl;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_REMOVE
    } t_state;

endpackage

[hw/rtl/ssds_cell.sv]
// One queue cell: holds an entry, loads a new one or takes its right neighbor's.
// Depends on ssds_pkg.
module ssds_cell (
    input  logic                           i_clk,
    input  ssds_pkg::t_cell_ctrl           i_ctrl,
    input  ssds_pkg::t_entry               i_new,
    input  ssds_pkg::t_entry               i_right,
    input  logic [ssds_pkg::TRACK_BITS-1:0] i_head,
    output ssds_pkg::t_entry               o_entry,
    output logic [ssds_pkg::TRACK_BITS-1:0] o_dist
);
    import ssds_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.load) begin
            n_entry = i_new;
        end else if (i_ctrl.shift) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    // Seek distance from the current head to this cell's track.
    assign o_dist  = (r_entry.track > i_head) ? (r_entry.track - i_head)
                                              : (i_head - r_entry.track);
    assign o_entry = r_entry;

endmodule

[hw/rtl/shortest_seek_disk_scheduler.sv]
// Top level of the shortest-seek-first disk scheduler.
// Depends on ssds_pkg and ssds_cell.
//
// Usage: items enter on the input channel (valid/ready) as a submit or a finish.
// Results leave on the output channel (valid/ready), one item each, with last
// set on the final result that an input item causes. Configuration writes use
// a separate valid/ready channel carrying a register index and data; it is
// always ready and must be written only while the block is idle.
// The queue is a row of cells, oldest entry in cell 0. Each serve scans the
// occupied cells one per cycle with a single distance compare, then passes
// through the remove and check states. A rejected submit returns its result
// from the output register in the cycle after acceptance, and a queued submit
// or a finish of an active requester that causes no serving frees the input once the check state returns to idle.
// A new input item is taken only when the block is idle and the output
// register is empty. If the receiver stalls, the finished result waits in the
// output register and the next served result waits in a holding register;
// serving pauses until the output register drains.
// Reset (synchronous, active low) empties the queue, clears all pending and
// finished flags, parks the head at track 0 and sets both limits to one.
module shortest_seek_disk_scheduler (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  ssds_pkg::t_in        i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output ssds_pkg::t_out       o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic                 i_cfg_index,
    input  logic [5:0]           i_cfg_data
);
    import ssds_pkg::*;

    t_state                    r_state, n_state;
    logic [LIMIT_W-1:0]        r_limit;
    logic [ACTIVE_W-1:0]       r_active;
    logic [MAX_REQUESTERS-1:0] r_pend, n_pend;
    logic [MAX_REQUESTERS-1:0] r_fin, n_fin;
    logic [TRACK_BITS-1:0]     r_head, n_head;
    logic [CNT_W-1:0]          r_count, n_count;
    logic [IDX_W-1:0]          r_idx, n_idx;
    logic [IDX_W-1:0]          r_best, n_best;
    logic [TRACK_BITS-1:0]     r_best_d, n_best_d;
    t_entry                    r_hold, n_hold;
    logic                      r_hold_v, n_hold_v;
    logic                      r_out_v, n_out_v;
    t_out                      r_out, n_out;

    t_entry                    w_entry [QUEUE_DEPTH];
    logic [TRACK_BITS-1:0]     w_dist  [QUEUE_DEPTH];
    t_cell_ctrl                w_ctrl  [QUEUE_DEPTH];
    t_entry                    w_new;
    logic                      w_append;
    logic                      w_remove;

    logic [CNT_W-1:0]          w_lim;
    logic [ACTIVE_W-1:0]       w_act;
    logic                      w_join;
    logic                      w_serve;
    logic                      w_out_free;
    logic                      w_in_acc;
    logic                      w_who_act;
    logic                      w_reject;

    // Effective limits: a zero queue limit acts as one, values past the sizes clamp.
    always_comb begin
        if (r_limit == '0) begin
            w_lim = CNT_W'(1);
        end else if (r_limit > LIMIT_W'(QUEUE_DEPTH)) begin
            w_lim = CNT_W'(QUEUE_DEPTH);
        end else begin
            w_lim = CNT_W'(r_limit);
        end
        if (r_active > ACTIVE_W'(MAX_REQUESTERS)) begin
            w_act = ACTIVE_W'(MAX_REQUESTERS);
        end else begin
            w_act = r_active;
        end
    end

    // Some active requester is neither finished nor waiting on the queue.
    always_comb begin
        w_join = 1'b0;
        for (int i = 0; i < MAX_REQUESTERS; i++) begin
            if ((ACTIVE_W'(i) < w_act) && !r_fin[i] && !r_pend[i]) begin
                w_join = 1'b1;
            end
        end
    end

    assign w_serve    = (r_count != '0) && ((r_count >= w_lim) || !w_join);
    assign w_out_free = !r_out_v || i_out_ready;
    assign o_in_ready = (r_state == ST_IDLE) && !r_out_v;
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_who_act  = ACTIVE_W'(i_in_data.requester) < w_act;
    assign w_reject   = (r_count >= w_lim) || !w_who_act ||
                        r_pend[i_in_data.requester] || r_fin[i_in_data.requester];
    assign w_append   = w_in_acc && (i_in_data.action == ACT_SUBMIT) && !w_reject;
    assign w_remove   = (r_state == ST_REMOVE);
    assign w_new      = '{owner: i_in_data.requester, track: i_in_data.track};

    // The cell row. Appends land in the first free cell; a removal closes the
    // gap by moving every later entry one cell toward the head of the row.
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        t_entry w_right;
        if (g == QUEUE_DEPTH - 1) begin : g_end
            assign w_right = w_entry[g];
        end else begin : g_mid
            assign w_right = w_entry[g+1];
        end
        assign w_ctrl[g] = '{load:  w_append && (r_count == CNT_W'(g)),
                             shift: w_remove && (IDX_W'(g) >= r_best)};
        ssds_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl[g]),
            .i_new   (w_new),
            .i_right (w_right),
            .i_head  (r_head),
            .o_entry (w_entry[g]),
            .o_dist  (w_dist[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_limit  <= LIMIT_W'(1);
            r_active <= ACTIVE_W'(1);
            r_pend   <= '0;
            r_fin    <= '0;
            r_head   <= '0;
            r_count  <= '0;
            r_hold_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pend   <= n_pend;
            r_fin    <= n_fin;
            r_head   <= n_head;
            r_count  <= n_count;
            r_hold_v <= n_hold_v;
            r_out_v  <= n_out_v;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_QUEUE_LIMIT: r_limit  <= i_cfg_data[LIMIT_W-1:0];
                    CFG_ACTIVE:      r_active <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_best   <= n_best;
        r_best_d <= n_best_d;
        r_hold   <= n_hold;
        r_out    <= n_out;
    end

    always_comb begin
        n_state  = r_state;
        n_pend   = r_pend;
        n_fin    = r_fin;
        n_head   = r_head;
        n_count  = r_count;
        n_idx    = r_idx;
        n_best   = r_best;
        n_best_d = r_best_d;
        n_hold   = r_hold;
        n_hold_v = r_hold_v;
        n_out    = r_out;
        n_out_v  = r_out_v && !i_out_ready;

        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (i_in_data.action == ACT_SUBMIT) begin
                        if (w_reject) begin
                            n_out_v = 1'b1;
                            n_out   = '{kind: KIND_REJECTED,
                                        served_requester: i_in_data.requester,
                                        served_track: i_in_data.track,
                                        last: 1'b1};
                        end else begin
                            n_count = r_count + CNT_W'(1);
                            n_pend[i_in_data.requester] = 1'b1;
                            n_state = ST_CHECK;
                        end
                    end else if (w_who_act) begin
                        n_fin[i_in_data.requester] = 1'b1;
                        n_state = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                // The held result is last exactly when no further serve follows.
                if (!r_hold_v || w_out_free) begin
                    if (r_hold_v) begin
                        n_out_v  = 1'b1;
                        n_out    = '{kind: KIND_SERVED,
                                     served_requester: r_hold.owner,
                                     served_track: r_hold.track,
                                     last: !w_serve};
                        n_hold_v = 1'b0;
                    end
                    if (w_serve) begin
                        n_idx   = '0;
                        n_state = ST_SCAN;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_SCAN: begin
                // Strictly smaller distance wins, so ties keep the older entry.
                if ((r_idx == '0) || (w_dist[r_idx] < r_best_d)) begin
                    n_best   = r_idx;
                    n_best_d = w_dist[r_idx];
                end
                if ((CNT_W'(r_idx) + CNT_W'(1)) == r_count) begin
                    n_state = ST_REMOVE;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            ST_REMOVE: begin
                n_hold   = w_entry[r_best];
                n_hold_v = 1'b1;
                n_head   = w_entry[r_best].track;
                n_pend[w_entry[r_best].owner] = 1'b0;
                n_count  = r_count - CNT_W'(1);
                n_state  = ST_CHECK;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

endmodule
